// File: rtl/trs_pkg.sv
// shared types and constants of the trs model matrix block
`timescale 1ns / 1ps

package trs_pkg;

   localparam int QUAT_W      = 16;
   localparam int FIX_W       = 32;
   localparam int QPROD_W     = 32;
   localparam int HALF_W      = 33;
   localparam int PROD_W      = 65;
   localparam int FRAC_SHIFT  = 27;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [HALF_W-1:0] ONE_Q27 = 33'sd134217728;
   localparam logic signed [FIX_W-1:0]  ONE_Q16 = 32'sd65536;

   localparam logic [1:0] COL_X    = 2'd0;
   localparam logic [1:0] COL_Y    = 2'd1;
   localparam logic [1:0] COL_Z    = 2'd2;
   localparam logic [1:0] LAST_COL = 2'd3;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [FIX_W-1:0]  pos_x;
      logic signed [FIX_W-1:0]  pos_y;
      logic signed [FIX_W-1:0]  pos_z;
      logic signed [FIX_W-1:0]  scale_x;
      logic signed [FIX_W-1:0]  scale_y;
      logic signed [FIX_W-1:0]  scale_z;
   } trs_req_type;

   typedef struct packed {
      logic [1:0]              column_index;
      logic signed [FIX_W-1:0] elem_row0;
      logic signed [FIX_W-1:0] elem_row1;
      logic signed [FIX_W-1:0] elem_row2;
      logic signed [FIX_W-1:0] elem_row3;
      logic                    last_column;
   } trs_rsp_type;

   // half rotation elements in Q27, named by column then row
   typedef struct packed {
      logic signed [HALF_W-1:0] h00;
      logic signed [HALF_W-1:0] h01;
      logic signed [HALF_W-1:0] h02;
      logic signed [HALF_W-1:0] h10;
      logic signed [HALF_W-1:0] h11;
      logic signed [HALF_W-1:0] h12;
      logic signed [HALF_W-1:0] h20;
      logic signed [HALF_W-1:0] h21;
      logic signed [HALF_W-1:0] h22;
      logic signed [FIX_W-1:0]  scale_x;
      logic signed [FIX_W-1:0]  scale_y;
      logic signed [FIX_W-1:0]  scale_z;
      logic signed [FIX_W-1:0]  pos_x;
      logic signed [FIX_W-1:0]  pos_y;
      logic signed [FIX_W-1:0]  pos_z;
   } trs_job_type;

endpackage

// File: rtl/trs_transform_matrix.sv
// trs model matrix: quaternion, translation and scale in, four matrix columns out
// path: input register, quaternion product registers, job queue, multiply stage, output register
// throughput: the back end issues one column per cycle through its three multipliers while
//   its multiply stage can advance; a 2-entry job queue decouples the ends
// reset: synchronous active high, empties all stages and the queue, no clearing pass
`timescale 1ns / 1ps

module trs_transform_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  trs_pkg::trs_req_type req_data,
   output logic                 empty,
   input  logic                 pop,
   output trs_pkg::trs_rsp_type rsp_data
);
   import trs_pkg::*;

   logic        job_push, job_full, job_pop, job_empty;
   trs_job_type job_wr, job_rd;

   trs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .job_push_o (job_push),
      .job_o      (job_wr),
      .job_full_i (job_full)
   );

   trs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (job_push),
      .data_i  (job_wr),
      .full_o  (job_full),
      .pop_i   (job_pop),
      .data_o  (job_rd),
      .empty_o (job_empty)
   );

   trs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_i       (job_rd),
      .job_valid_i (!job_empty),
      .job_pop_o   (job_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule

// File: rtl/trs_front.sv
// front end: input register, quaternion products and half rotation elements
`timescale 1ns / 1ps

module trs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  trs_pkg::trs_req_type req_data,
   output logic                 job_push_o,
   output trs_pkg::trs_job_type job_o,
   input  logic                 job_full_i
);
   import trs_pkg::*;

   logic                      a_valid_ff, a_valid_in;
   trs_req_type               a_req_ff;
   logic                      b_valid_ff, b_valid_in;
   logic signed [QPROD_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [QPROD_W-1:0] wx_ff, wy_ff, wz_ff;
   logic signed [FIX_W-1:0]   sx_ff, sy_ff, sz_ff, px_ff, py_ff, pz_ff;
   logic                      a_ready, b_ready, a_load, b_load;

   assign b_ready = !b_valid_ff || !job_full_i;
   assign a_ready = !a_valid_ff || b_ready;
   assign full    = !a_ready;
   assign a_load  = push && a_ready;
   assign b_load  = a_valid_ff && b_ready;

   assign a_valid_in = a_ready ? push : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_req_ff <= req_data;
      end
      if (b_load) begin
         xx_ff <= QPROD_W'(a_req_ff.quat_x) * QPROD_W'(a_req_ff.quat_x);
         yy_ff <= QPROD_W'(a_req_ff.quat_y) * QPROD_W'(a_req_ff.quat_y);
         zz_ff <= QPROD_W'(a_req_ff.quat_z) * QPROD_W'(a_req_ff.quat_z);
         xy_ff <= QPROD_W'(a_req_ff.quat_x) * QPROD_W'(a_req_ff.quat_y);
         xz_ff <= QPROD_W'(a_req_ff.quat_x) * QPROD_W'(a_req_ff.quat_z);
         yz_ff <= QPROD_W'(a_req_ff.quat_y) * QPROD_W'(a_req_ff.quat_z);
         wx_ff <= QPROD_W'(a_req_ff.quat_w) * QPROD_W'(a_req_ff.quat_x);
         wy_ff <= QPROD_W'(a_req_ff.quat_w) * QPROD_W'(a_req_ff.quat_y);
         wz_ff <= QPROD_W'(a_req_ff.quat_w) * QPROD_W'(a_req_ff.quat_z);
         sx_ff <= a_req_ff.scale_x;
         sy_ff <= a_req_ff.scale_y;
         sz_ff <= a_req_ff.scale_z;
         px_ff <= a_req_ff.pos_x;
         py_ff <= a_req_ff.pos_y;
         pz_ff <= a_req_ff.pos_z;
      end
   end

   // diagonal: 1 - (a*a + b*b), off diagonal: a*b +/- c*d, all halved in Q27
   always_comb begin
      job_o.h00     = ONE_Q27 - (HALF_W'(yy_ff) + HALF_W'(zz_ff));
      job_o.h01     = HALF_W'(xy_ff) + HALF_W'(wz_ff);
      job_o.h02     = HALF_W'(xz_ff) - HALF_W'(wy_ff);
      job_o.h10     = HALF_W'(xy_ff) - HALF_W'(wz_ff);
      job_o.h11     = ONE_Q27 - (HALF_W'(xx_ff) + HALF_W'(zz_ff));
      job_o.h12     = HALF_W'(yz_ff) + HALF_W'(wx_ff);
      job_o.h20     = HALF_W'(xz_ff) + HALF_W'(wy_ff);
      job_o.h21     = HALF_W'(yz_ff) - HALF_W'(wx_ff);
      job_o.h22     = ONE_Q27 - (HALF_W'(xx_ff) + HALF_W'(yy_ff));
      job_o.scale_x = sx_ff;
      job_o.scale_y = sy_ff;
      job_o.scale_z = sz_ff;
      job_o.pos_x   = px_ff;
      job_o.pos_y   = py_ff;
      job_o.pos_z   = pz_ff;
   end

   assign job_push_o = b_valid_ff && !job_full_i;

endmodule

// File: rtl/trs_queue.sv
// short job queue between front end and back end
`timescale 1ns / 1ps

module trs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_i,
   input  trs_pkg::trs_job_type data_i,
   output logic                 full_o,
   input  logic                 pop_i,
   output trs_pkg::trs_job_type data_o,
   output logic                 empty_o
);
   import trs_pkg::*;

   trs_job_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

   assign full_o  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty_o = (count_ff == '0);
   assign data_o  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_i  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_i && !push_i) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entry_ff[wr_ptr_ff] <= data_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i && !pop_i |-> !full_o)
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> !empty_o)
      else $error("job queue read while empty");

endmodule

// File: rtl/trs_back.sv
// back end: one column per cycle while the output is not stalled, through multiply, round and saturate stages
`timescale 1ns / 1ps

module trs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  trs_pkg::trs_job_type job_i,
   input  logic                 job_valid_i,
   output logic                 job_pop_o,
   output logic                 empty,
   input  logic                 pop,
   output trs_pkg::trs_rsp_type rsp_data
);
   import trs_pkg::*;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(ONE_Q27 >>> 1);
   localparam logic signed [PROD_W-1:0] SAT_HI     = PROD_W'(32'sh7FFFFFFF);
   localparam logic signed [PROD_W-1:0] SAT_LO     = PROD_W'(32'sh80000000);

   logic [1:0]               col_ff, col_in;
   logic signed [HALF_W-1:0] h0, h1, h2;
   logic signed [FIX_W-1:0]  m0, m1, m2;
   logic                     issue, s1_ready, s2_ready;
   logic                     s1_valid_ff, s1_valid_in;
   logic [1:0]               s1_col_ff;
   logic signed [PROD_W-1:0] s1_p0_ff, s1_p1_ff, s1_p2_ff;
   logic                     s2_valid_ff, s2_valid_in;
   trs_rsp_type              rsp_ff, rsp_in;

   // add half an lsb, floor, clamp to 32 bits
   function automatic logic signed [FIX_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      logic signed [FIX_W-1:0]  q;
      r = (p + ROUND_BIAS) >>> FRAC_SHIFT;
      if (r > SAT_HI) begin
         q = SAT_HI[FIX_W-1:0];
      end else if (r < SAT_LO) begin
         q = SAT_LO[FIX_W-1:0];
      end else begin
         q = r[FIX_W-1:0];
      end
      return q;
   endfunction

   assign s2_ready  = !s2_valid_ff || pop;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign issue     = job_valid_i && s1_ready;
   assign job_pop_o = issue && (col_ff == LAST_COL);
   assign col_in    = issue ? col_ff + 2'd1 : col_ff;

   // translation column goes through the same multipliers as pos * 1.0
   always_comb begin
      case (col_ff)
         COL_X: begin
            h0 = job_i.h00; h1 = job_i.h01; h2 = job_i.h02;
            m0 = job_i.scale_x; m1 = job_i.scale_x; m2 = job_i.scale_x;
         end
         COL_Y: begin
            h0 = job_i.h10; h1 = job_i.h11; h2 = job_i.h12;
            m0 = job_i.scale_y; m1 = job_i.scale_y; m2 = job_i.scale_y;
         end
         COL_Z: begin
            h0 = job_i.h20; h1 = job_i.h21; h2 = job_i.h22;
            m0 = job_i.scale_z; m1 = job_i.scale_z; m2 = job_i.scale_z;
         end
         default: begin
            h0 = ONE_Q27; h1 = ONE_Q27; h2 = ONE_Q27;
            m0 = job_i.pos_x; m1 = job_i.pos_y; m2 = job_i.pos_z;
         end
      endcase
   end

   assign s1_valid_in = s1_ready ? job_valid_i : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      rsp_in.column_index = s1_col_ff;
      rsp_in.elem_row0    = round_sat(s1_p0_ff);
      rsp_in.elem_row1    = round_sat(s1_p1_ff);
      rsp_in.elem_row2    = round_sat(s1_p2_ff);
      rsp_in.elem_row3    = (s1_col_ff == LAST_COL) ? ONE_Q16 : '0;
      rsp_in.last_column  = (s1_col_ff == LAST_COL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= COL_X;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_col_ff <= col_ff;
         s1_p0_ff  <= PROD_W'(h0) * PROD_W'(m0);
         s1_p1_ff  <= PROD_W'(h1) * PROD_W'(m1);
         s1_p2_ff  <= PROD_W'(h2) * PROD_W'(m2);
      end
      if (s1_valid_ff && s2_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = !s2_valid_ff;
   assign rsp_data = rsp_ff;

   a_col_holds: assert property (@(posedge clock) disable iff (reset)
      !issue |=> $stable(col_ff))
      else $error("column counter moved without an issue");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("multiply stage lost its column while stalled");

   a_last_row3: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (rsp_ff.last_column == (rsp_ff.column_index == LAST_COL)) &&
                      (rsp_ff.elem_row3 == (rsp_ff.last_column ? ONE_Q16 : '0)))
      else $error("row 3 or last flag inconsistent with column");

endmodule

// File: tb/sv/trs_matrix_checker.sv
// checker for trs_transform_matrix: predicts the four matrix columns and compares them
`timescale 1ns / 1ps

module trs_matrix_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 full,
   input  trs_pkg::trs_req_type req_data,
   input  logic                 empty,
   input  logic                 pop,
   input  trs_pkg::trs_rsp_type rsp_data,
   output int                   mismatch_count,
   output int                   columns_pending,
   output int                   columns_checked,
   output int                   transforms_seen
);
   import trs_pkg::*;

   trs_rsp_type expected_columns[$];
   trs_rsp_type want;

   function automatic logic signed [FIX_W-1:0] saturate_fix(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[FIX_W-1:0];
   endfunction

   // half element in Q27 times Q16.16 scale, round half up, back to Q16.16
   function automatic logic signed [FIX_W-1:0] scale_half_element(longint half, longint scale);
      longint prod;
      prod = half * scale + 64'sd67108864;
      return saturate_fix(prod >>> FRAC_SHIFT);
   endfunction

   function automatic void predict_matrix(trs_req_type t);
      longint qx, qy, qz, qw;
      longint one_half;
      longint half[3][3];
      longint scale[3];
      trs_rsp_type col;
      qx = $signed(t.quat_x);
      qy = $signed(t.quat_y);
      qz = $signed(t.quat_z);
      qw = $signed(t.quat_w);
      one_half = longint'(ONE_Q27);
      scale[0] = $signed(t.scale_x);
      scale[1] = $signed(t.scale_y);
      scale[2] = $signed(t.scale_z);
      // indexed [column][row]
      half[0][0] = one_half - (qy * qy + qz * qz);
      half[0][1] = qx * qy + qw * qz;
      half[0][2] = qx * qz - qw * qy;
      half[1][0] = qx * qy - qw * qz;
      half[1][1] = one_half - (qx * qx + qz * qz);
      half[1][2] = qy * qz + qw * qx;
      half[2][0] = qx * qz + qw * qy;
      half[2][1] = qy * qz - qw * qx;
      half[2][2] = one_half - (qx * qx + qy * qy);
      for (int c = 0; c < 3; c++) begin
         col.column_index = (c == 0) ? COL_X : (c == 1) ? COL_Y : COL_Z;
         col.elem_row0    = scale_half_element(half[c][0], scale[c]);
         col.elem_row1    = scale_half_element(half[c][1], scale[c]);
         col.elem_row2    = scale_half_element(half[c][2], scale[c]);
         col.elem_row3    = '0;
         col.last_column  = 1'b0;
         expected_columns.push_back(col);
      end
      col.column_index = LAST_COL;
      col.elem_row0    = t.pos_x;
      col.elem_row1    = t.pos_y;
      col.elem_row2    = t.pos_z;
      col.elem_row3    = ONE_Q16;
      col.last_column  = 1'b1;
      expected_columns.push_back(col);
   endfunction

   task automatic check_field(string field, logic [FIX_W-1:0] expected, logic [FIX_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %h, got %h", field, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_columns.delete();
         mismatch_count  = 0;
         columns_checked = 0;
         transforms_seen = 0;
      end else begin
         if (push && !full) begin
            predict_matrix(req_data);
            transforms_seen++;
         end
         if (pop && !empty) begin
            if (expected_columns.size() == 0) begin
               $error("column transaction with none expected: index %0d", rsp_data.column_index);
               mismatch_count++;
            end else begin
               want = expected_columns.pop_front();
               check_field("column_index", FIX_W'(want.column_index),
                  FIX_W'(rsp_data.column_index));
               check_field("elem_row0", want.elem_row0, rsp_data.elem_row0);
               check_field("elem_row1", want.elem_row1, rsp_data.elem_row1);
               check_field("elem_row2", want.elem_row2, rsp_data.elem_row2);
               check_field("elem_row3", want.elem_row3, rsp_data.elem_row3);
               check_field("last_column", FIX_W'(want.last_column),
                  FIX_W'(rsp_data.last_column));
               columns_checked++;
            end
         end
      end
      columns_pending = expected_columns.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// testbench top for trs_transform_matrix: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_top;
   import trs_pkg::*;

   localparam int RANDOM_PER_PHASE = 60;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = 24;
   localparam logic signed [QUAT_W-1:0] Q_ONE        = 16'sd16384;
   localparam logic signed [QUAT_W-1:0] Q_HALF_SQRT2 = 16'sd11585;
   localparam int FIX_ONE          = 65536;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push  = 1'b0;
   logic        pop   = 1'b0;
   trs_req_type req_data = '0;
   logic        full;
   logic        empty;
   trs_rsp_type rsp_data;

   int send_idle_pct = 6;
   int recv_idle_pct = 86;
   int cycle_count   = 0;
   int mismatch_count;
   int columns_pending;
   int columns_checked;
   int transforms_seen;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   trs_transform_matrix dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   trs_matrix_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data        (req_data),
      .empty           (empty),
      .pop             (pop),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .columns_pending (columns_pending),
      .columns_checked (columns_checked),
      .transforms_seen (transforms_seen)
   );

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic trs_req_type make_transform(
      logic signed [QUAT_W-1:0] qx, logic signed [QUAT_W-1:0] qy,
      logic signed [QUAT_W-1:0] qz, logic signed [QUAT_W-1:0] qw,
      logic signed [FIX_W-1:0] px, logic signed [FIX_W-1:0] py, logic signed [FIX_W-1:0] pz,
      logic signed [FIX_W-1:0] sx, logic signed [FIX_W-1:0] sy, logic signed [FIX_W-1:0] sz);
      trs_req_type t;
      t.quat_x  = qx;
      t.quat_y  = qy;
      t.quat_z  = qz;
      t.quat_w  = qw;
      t.pos_x   = px;
      t.pos_y   = py;
      t.pos_z   = pz;
      t.scale_x = sx;
      t.scale_y = sy;
      t.scale_z = sz;
      return t;
   endfunction

   function automatic logic signed [QUAT_W-1:0] pick_quat();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         3, 4, 5: return 16'(int'($urandom_range(2 * Q_ONE)) - Q_ONE);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [FIX_W-1:0] pick_fix(bit modest);
      if (modest) return 32'(int'($urandom_range(32 * FIX_ONE)) - 16 * FIX_ONE);
      case ($urandom_range(9))
         0:       return 32'sh7FFFFFFF;
         1:       return 32'sh80000000;
         2:       return '0;
         3:       return FIX_ONE;
         4:       return -FIX_ONE;
         5, 6:    return 32'(int'($urandom_range(32 * FIX_ONE)) - 16 * FIX_ONE);
         default: return 32'($urandom);
      endcase
   endfunction

   // mostly unit quaternions, most with everyday scale and offset, the rest raw field noise
   function automatic trs_req_type random_transform();
      trs_req_type t;
      real q[4];
      real norm;
      bit modest;
      if ($urandom_range(9) < 6) begin
         for (int i = 0; i < 4; i++) q[i] = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
         norm = $sqrt(q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3]);
         if (norm < 0.01) begin
            q = '{0.0, 0.0, 0.0, 1.0};
            norm = 1.0;
         end
         t.quat_x = 16'($rtoi(q[0] / norm * Q_ONE));
         t.quat_y = 16'($rtoi(q[1] / norm * Q_ONE));
         t.quat_z = 16'($rtoi(q[2] / norm * Q_ONE));
         t.quat_w = 16'($rtoi(q[3] / norm * Q_ONE));
         modest = ($urandom_range(3) != 0);
      end else begin
         t.quat_x = pick_quat();
         t.quat_y = pick_quat();
         t.quat_z = pick_quat();
         t.quat_w = pick_quat();
         modest = 1'b0;
      end
      t.pos_x   = pick_fix(modest);
      t.pos_y   = pick_fix(modest);
      t.pos_z   = pick_fix(modest);
      t.scale_x = pick_fix(modest);
      t.scale_y = pick_fix(modest);
      t.scale_z = pick_fix(modest);
      return t;
   endfunction

   // entered and left at a falling edge; push stays high across back-to-back transactions
   task automatic send_transform(trs_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity, then all fields at their extremes
      send_transform(make_transform(0, 0, 0, Q_ONE, 0, 0, 0, FIX_ONE, FIX_ONE, FIX_ONE));
      send_transform(make_transform(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
         32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
      send_transform(make_transform(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
         32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
      send_transform(make_transform(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
         32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
      // zero quaternion leaves only the diagonal
      send_transform(make_transform(0, 0, 0, 0,
         32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh80000000, FIX_ONE));
      send_transform(make_transform(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // quarter and half turns
      send_transform(make_transform(0, 0, Q_HALF_SQRT2, Q_HALF_SQRT2,
         FIX_ONE + FIX_ONE / 2, -2 * FIX_ONE, 3 * FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE));
      send_transform(make_transform(Q_ONE, 0, 0, 0, 0, 0, 0, FIX_ONE, 2 * FIX_ONE, 3 * FIX_ONE));
      send_transform(make_transform(0, Q_HALF_SQRT2, 0, Q_HALF_SQRT2,
         -FIX_ONE, FIX_ONE, -FIX_ONE, -FIX_ONE, -FIX_ONE, -FIX_ONE));
      // exact rounding ties, one above zero and one below, then small products under negative scale
      send_transform(make_transform(1, 1, 0, 0, 0, 0, 0,
         32'sh04000000, 32'sh04000000, 32'sh04000000));
      send_transform(make_transform(1, -1, 0, 0, 0, 0, 0,
         32'sh04000000, 32'sh04000000, 32'sh04000000));
      send_transform(make_transform(1, -1, 1, 1, 0, 0, 0,
         -32'sh04000000, -32'sh04000000, -32'sh04000000));
      // non-unit quaternion
      send_transform(make_transform(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1, -1, 32'sh7FFFFFFF,
         FIX_ONE, FIX_ONE, FIX_ONE));
      // zero scale collapses the rotation columns
      send_transform(make_transform(5000, -7000, 9000, 11000, 0, 0, 0, 0, 0, 0));

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) send_transform(random_transform());
      end
      push <= 1'b0;

      while (columns_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("checked %0d matrix columns from %0d transforms: corner cases, then random",
         columns_checked, transforms_seen);
      $display("transforms under sender-bound, receiver-bound and unthrottled traffic");
      if (mismatch_count == 0 && columns_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
